// ===== hdl/rqn_pkg.sv =====
// Shared types and fixed-point constants for the RGB 2x2 block to NV12 converter.
package rqn_pkg;

	// One 2x2 block of 8-bit RGB pixels, upper row first, even column first.
	typedef struct packed {
		logic [7:0] top_left_red;
		logic [7:0] top_left_green;
		logic [7:0] top_left_blue;
		logic [7:0] top_right_red;
		logic [7:0] top_right_green;
		logic [7:0] top_right_blue;
		logic [7:0] bottom_left_red;
		logic [7:0] bottom_left_green;
		logic [7:0] bottom_left_blue;
		logic [7:0] bottom_right_red;
		logic [7:0] bottom_right_green;
		logic [7:0] bottom_right_blue;
	} quad_t;

	// Four luma bytes and the shared Cb, Cr pair of one block.
	typedef struct packed {
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} ycc_t;

	// Signed Q15 weights of one chroma component.
	typedef struct packed {
		logic signed [15:0] red;
		logic signed [15:0] green;
		logic signed [15:0] blue;
	} chroma_coef_t;

	// Luma weights in Q15, offset is 16 in Q6 plus half an LSB.
	localparam logic [14:0] LUMA_RED_COEF   = 15'd8421;
	localparam logic [14:0] LUMA_GREEN_COEF = 15'd16515;
	localparam logic [14:0] LUMA_BLUE_COEF  = 15'd3211;
	localparam logic [15:0] LUMA_OFFSET     = 16'd1056;

	// Chroma weights apply to four-pixel sums, so they carry an extra factor of two.
	localparam chroma_coef_t CB_COEF = '{
		red:   -16'sd9699,
		green: -16'sd19071,
		blue:  16'sd28770
	};
	localparam chroma_coef_t CR_COEF = '{
		red:   16'sd28770,
		green: -16'sd24117,
		blue:  -16'sd4653
	};
	localparam logic signed [13:0] CHROMA_OFFSET = 14'sd1028;

endpackage

// ===== hdl/rqn_luma.sv =====
// Luma of one pixel: three rounded Q15 products, offset, scale and clamp.
module rqn_luma import rqn_pkg::*; (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] luma
);

	logic [22:0] prod_red;
	logic [22:0] prod_green;
	logic [22:0] prod_blue;
	logic [13:0] term_red;
	logic [13:0] term_green;
	logic [13:0] term_blue;
	logic [15:0] total;
	logic [9:0]  scaled;

	// Rounding (64*x*k + 2^14) >> 15 is the same as (x*k + 256) >> 9.
	assign prod_red   = 23'(red)   * 23'(LUMA_RED_COEF);
	assign prod_green = 23'(green) * 23'(LUMA_GREEN_COEF);
	assign prod_blue  = 23'(blue)  * 23'(LUMA_BLUE_COEF);

	assign term_red   = 14'((prod_red   + 23'd256) >> 9);
	assign term_green = 14'((prod_green + 23'd256) >> 9);
	assign term_blue  = 14'((prod_blue  + 23'd256) >> 9);

	assign total  = 16'(term_red) + 16'(term_green) + 16'(term_blue) + LUMA_OFFSET;
	assign scaled = total[15:6];
	assign luma   = (scaled > 10'd255) ? 8'hFF : scaled[7:0];

endmodule

// ===== hdl/rqn_chroma.sv =====
// One chroma component from the four-pixel channel sums, with rounding and clamp.
module rqn_chroma import rqn_pkg::*; (
	input  logic [9:0]   sum_red,
	input  logic [9:0]   sum_green,
	input  logic [9:0]   sum_blue,
	input  chroma_coef_t coef,
	output logic [7:0]   chroma
);

	logic signed [26:0] prod_red;
	logic signed [26:0] prod_green;
	logic signed [26:0] prod_blue;
	logic signed [11:0] term_red;
	logic signed [11:0] term_green;
	logic signed [11:0] term_blue;
	logic signed [13:0] total;
	logic [10:0]        scaled;

	assign prod_red   = $signed({17'b0, sum_red})   * 27'(coef.red);
	assign prod_green = $signed({17'b0, sum_green}) * 27'(coef.green);
	assign prod_blue  = $signed({17'b0, sum_blue})  * 27'(coef.blue);

	// Arithmetic shift gives the floor for negative products.
	assign term_red   = 12'((prod_red   + 27'sd16384) >>> 15);
	assign term_green = 12'((prod_green + 27'sd16384) >>> 15);
	assign term_blue  = 12'((prod_blue  + 27'sd16384) >>> 15);

	assign total  = 14'(term_red) + 14'(term_green) + 14'(term_blue) + CHROMA_OFFSET;
	assign scaled = total[13:3];

	always_comb begin
		if (total < 14'sd0) begin
			chroma = 8'h00;
		end else if (scaled > 11'd255) begin
			chroma = 8'hFF;
		end else begin
			chroma = scaled[7:0];
		end
	end

endmodule

// ===== hdl/rgb_quad_to_nv12_bt601_top.sv =====
// Top level of the RGB 2x2 block to BT.601 NV12 luma and chroma converter.

// Converts one 2x2 block of 8-bit RGB pixels per clock into four luma bytes and one
// Cb, Cr pair (BT.601 studio range, 4:2:0 as in NV12). A request is taken at every
// rising edge where start is high and busy is low; busy is high only from reset until
// the first clock edge after reset is released, so after that a new block may be
// presented in every cycle. The block is a two-register pipeline: the request is
// captured in an input register, the arithmetic runs in one pass of constant
// multipliers and adders, and the answer lands in the result register. Each result
// then sits on the result port with done high for exactly one cycle. The receiver
// cannot hold results off, so it must capture result in every cycle where done is
// high. Image addressing, row pairing and plane layout are left to the surrounding
// logic.
module rgb_quad_to_nv12_bt601_top import rqn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  quad_t pixels,
	output logic  done,
	output ycc_t  result
);

	logic  busy_q;
	logic  valid_s1;
	quad_t pixels_s1;
	logic  valid_s2;
	ycc_t  result_s2;
	ycc_t  result_next;
	logic  accept;

	logic [9:0] sum_red;
	logic [9:0] sum_green;
	logic [9:0] sum_blue;

	assign accept = start && !busy_q;

	// Busy only covers the first edge out of reset; the pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixels_s1 <= pixels;
		end
		if (valid_s1) begin
			result_s2 <= result_next;
		end
	end

	rqn_luma u_luma_tl (
		.red   (pixels_s1.top_left_red),
		.green (pixels_s1.top_left_green),
		.blue  (pixels_s1.top_left_blue),
		.luma  (result_next.luma_top_left)
	);

	rqn_luma u_luma_tr (
		.red   (pixels_s1.top_right_red),
		.green (pixels_s1.top_right_green),
		.blue  (pixels_s1.top_right_blue),
		.luma  (result_next.luma_top_right)
	);

	rqn_luma u_luma_bl (
		.red   (pixels_s1.bottom_left_red),
		.green (pixels_s1.bottom_left_green),
		.blue  (pixels_s1.bottom_left_blue),
		.luma  (result_next.luma_bottom_left)
	);

	rqn_luma u_luma_br (
		.red   (pixels_s1.bottom_right_red),
		.green (pixels_s1.bottom_right_green),
		.blue  (pixels_s1.bottom_right_blue),
		.luma  (result_next.luma_bottom_right)
	);

	// Chroma is taken from the channel sums over the four pixels, each up to 1020.
	assign sum_red = 10'(pixels_s1.top_left_red) + 10'(pixels_s1.top_right_red)
		+ 10'(pixels_s1.bottom_left_red) + 10'(pixels_s1.bottom_right_red);
	assign sum_green = 10'(pixels_s1.top_left_green) + 10'(pixels_s1.top_right_green)
		+ 10'(pixels_s1.bottom_left_green) + 10'(pixels_s1.bottom_right_green);
	assign sum_blue = 10'(pixels_s1.top_left_blue) + 10'(pixels_s1.top_right_blue)
		+ 10'(pixels_s1.bottom_left_blue) + 10'(pixels_s1.bottom_right_blue);

	rqn_chroma u_chroma_blue (
		.sum_red   (sum_red),
		.sum_green (sum_green),
		.sum_blue  (sum_blue),
		.coef      (CB_COEF),
		.chroma    (result_next.chroma_blue)
	);

	rqn_chroma u_chroma_red (
		.sum_red   (sum_red),
		.sum_green (sum_green),
		.sum_blue  (sum_blue),
		.coef      (CR_COEF),
		.chroma    (result_next.chroma_red)
	);

	assign busy   = busy_q;
	assign done   = valid_s2;
	assign result = result_s2;

`ifndef SYNTHESIS
	// Every accepted request shows up as a strobe once it has passed the input and result registers.
	a_strobe_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing two cycles after a request");

	a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request in the input stage");

	// Once out of reset the block never stalls the sender.
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset");

	// Studio range: top-left and bottom-right luma within 16..235, chroma within 16..240.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.luma_top_left >= 8'd16 && result.luma_top_left <= 8'd235
			&& result.luma_bottom_right >= 8'd16 && result.luma_bottom_right <= 8'd235
			&& result.chroma_blue >= 8'd16 && result.chroma_blue <= 8'd240
			&& result.chroma_red >= 8'd16 && result.chroma_red <= 8'd240))
		else $error("result outside studio range");
`endif

endmodule
